[hdl/cca_pkg.sv]
// shared types and constants for the cave cellular automaton
// no dependencies
package cca_pkg;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic       cell_in;
	} cca_in_t;

	typedef struct packed {
		logic cell_out;
		logic run_done;
	} cca_out_t;

	// sequencer status seen by the top level
	typedef struct packed {
		logic busy;
		logic done;
	} cca_stat_t;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_RUN  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [2:0] REG_GRID_WIDTH   = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_MAIN_STEPS   = 3'd2;
	localparam logic [2:0] REG_MIRROR_STEPS = 3'd3;
	localparam logic [2:0] REG_BIRTH_LIMIT  = 3'd4;
	localparam logic [2:0] REG_DEATH_LIMIT  = 3'd5;

	// neighbor slot that holds the cell itself
	localparam logic [3:0] NB_CENTER = 4'd4;
	localparam logic [3:0] NB_LAST   = 4'd8;

endpackage

[hdl/cave_cellular_automaton.sv]
// top level of the cave cellular automaton: command decode, config registers,
// grid rams and result register; depends on cca_pkg, cca_ram, cca_seq
//
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   cca_in_t  (load, run, read)
// out      output     out_valid/out_stall cca_out_t (read value or run done)
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a load writes the grid ram directly; a read goes through the registered ram read
// and the result register; a run step reads the grid ram nine times per cell,
// writes, then copies back; a mirror pass covers half the grid
// reset clears control state only; grid contents are undefined until loaded
// in_stall is held high during a run and while a result waits in the output register
module cave_cellular_automaton import cca_pkg::*; #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  cca_in_t    in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output cca_out_t   out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int XW = $clog2(MAX_COLS);
	localparam int YW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int AW = XW + YW;

	logic [6:0] grid_width_q, grid_height_q;
	logic [7:0] main_steps_q, mirror_steps_q;
	logic [3:0] birth_limit_q, death_limit_q;

	logic [CW-1:0] w;
	logic [RW-1:0] h;

	cca_stat_t stat;
	logic          seq_a_we, seq_a_wdata, b_we, b_wdata, a_rdata, b_rdata;
	logic [AW-1:0] seq_a_raddr, seq_a_waddr, b_raddr, b_waddr;
	logic          a_we, a_wdata;
	logic [AW-1:0] a_waddr, a_raddr, cmd_addr;

	logic     accept, in_store, out_free;
	logic     rd_s1, inside_s1;
	logic     done_pend_q;
	logic     out_vld_q;
	cca_out_t out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= 7'd64;
			grid_height_q  <= 7'd64;
			main_steps_q   <= 8'd0;
			mirror_steps_q <= 8'd0;
			birth_limit_q  <= 4'd5;
			death_limit_q  <= 4'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:   grid_width_q   <= cfg_data[6:0];
				REG_GRID_HEIGHT:  grid_height_q  <= cfg_data[6:0];
				REG_MAIN_STEPS:   main_steps_q   <= cfg_data;
				REG_MIRROR_STEPS: mirror_steps_q <= cfg_data;
				REG_BIRTH_LIMIT:  birth_limit_q  <= cfg_data[3:0];
				REG_DEATH_LIMIT:  death_limit_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamp the sizes in use to 1..MAX
	always_comb begin
		if (grid_width_q == '0) begin
			w = CW'(1);
		end else if (32'(grid_width_q) > MAX_COLS) begin
			w = CW'(MAX_COLS);
		end else begin
			w = CW'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			h = RW'(1);
		end else if (32'(grid_height_q) > MAX_ROWS) begin
			h = RW'(MAX_ROWS);
		end else begin
			h = RW'(grid_height_q);
		end
	end

	assign out_free = !out_vld_q || !out_stall;
	assign in_stall = stat.busy || done_pend_q || rd_s1 || !out_free;
	assign accept   = in_valid && !in_stall;
	assign in_store = (32'(in_data.cell_x) < MAX_COLS) && (32'(in_data.cell_y) < MAX_ROWS);
	assign cmd_addr = {YW'(in_data.cell_y), XW'(in_data.cell_x)};

	assign a_we    = stat.busy ? seq_a_we : (accept && in_data.kind == KIND_LOAD && in_store);
	assign a_waddr = stat.busy ? seq_a_waddr : cmd_addr;
	assign a_wdata = stat.busy ? seq_a_wdata : in_data.cell_in;
	assign a_raddr = stat.busy ? seq_a_raddr : cmd_addr;

	cca_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_grid (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	cca_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_next (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	cca_seq #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept && in_data.kind == KIND_RUN),
		.w            (w),
		.h            (h),
		.main_steps   (main_steps_q),
		.mirror_steps (mirror_steps_q),
		.birth_limit  (birth_limit_q),
		.death_limit  (death_limit_q),
		.a_rdata      (a_rdata),
		.b_rdata      (b_rdata),
		.a_raddr      (seq_a_raddr),
		.a_we         (seq_a_we),
		.a_waddr      (seq_a_waddr),
		.a_wdata      (seq_a_wdata),
		.b_raddr      (b_raddr),
		.b_we         (b_we),
		.b_waddr      (b_waddr),
		.b_wdata      (b_wdata),
		.stat         (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1       <= 1'b0;
			done_pend_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			rd_s1 <= accept && in_data.kind == KIND_READ;
			if (rd_s1) begin
				out_vld_q <= 1'b1;
			end else if (done_pend_q && out_free) begin
				out_vld_q   <= 1'b1;
				done_pend_q <= 1'b0;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			if (stat.done) begin
				done_pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		inside_s1 <= in_store;
		if (rd_s1) begin
			out_q.cell_out <= inside_s1 & a_rdata;
			out_q.run_done <= 1'b0;
		end else if (done_pend_q && out_free) begin
			out_q.cell_out <= 1'b0;
			out_q.run_done <= 1'b1;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

[hdl/cca_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
module cca_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/cca_seq.sv]
// run sequencer: automaton steps, copy back and mirror passes over the grid rams
// depends on cca_pkg
module cca_seq import cca_pkg::*; #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64,
	parameter int XW = $clog2(MAX_COLS),
	parameter int YW = $clog2(MAX_ROWS),
	parameter int CW = $clog2(MAX_COLS + 1),
	parameter int RW = $clog2(MAX_ROWS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CW-1:0]    w,
	input  logic [RW-1:0]    h,
	input  logic [7:0]       main_steps,
	input  logic [7:0]       mirror_steps,
	input  logic [3:0]       birth_limit,
	input  logic [3:0]       death_limit,
	input  logic             a_rdata,
	input  logic             b_rdata,
	output logic [XW+YW-1:0] a_raddr,
	output logic             a_we,
	output logic [XW+YW-1:0] a_waddr,
	output logic             a_wdata,
	output logic [XW+YW-1:0] b_raddr,
	output logic             b_we,
	output logic [XW+YW-1:0] b_waddr,
	output logic             b_wdata,
	output cca_stat_t        stat
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_NEXT    = 7'b0000010,
		S_STEP_RD = 7'b0000100,
		S_STEP_WR = 7'b0001000,
		S_XFER    = 7'b0010000,
		S_DRAIN   = 7'b0100000,
		S_FIN     = 7'b1000000
	} state_t;

	localparam logic [2:0] PH_MAIN = 3'd0;
	localparam logic [2:0] PH_MCOL = 3'd1;
	localparam logic [2:0] PH_MS1  = 3'd2;
	localparam logic [2:0] PH_MROW = 3'd3;
	localparam logic [2:0] PH_MS2  = 3'd4;
	localparam logic [2:0] PH_END  = 3'd5;

	localparam logic [1:0] MODE_COPY = 2'd0;
	localparam logic [1:0] MODE_MCOL = 2'd1;
	localparam logic [1:0] MODE_MROW = 2'd2;

	state_t            state_q;
	logic [2:0]        phase_q;
	logic [7:0]        steps_q;
	logic [1:0]        mode_q;
	logic [XW-1:0]     x_q;
	logic [YW-1:0]     y_q;
	logic [CW-1:0]     xl_q;
	logic [RW-1:0]     yl_q;
	logic [3:0]        nb_q;
	logic [3:0]        sum_q;
	logic              center_q;
	logic              st_vld_s1;
	logic              out_s1;
	logic [3:0]        nb_s1;
	logic              xf_vld_s1;
	logic [XW+YW-1:0]  waddr_s1;

	logic [1:0]        col, row;
	logic              outside;
	logic [XW-1:0]     nx;
	logic [YW-1:0]     ny;
	logic [XW+YW-1:0]  dst;
	logic              term;
	logic [3:0]        sum_fin;
	logic              new_cell;
	logic              last_col, last_cell;

	always_comb begin
		case (nb_q)
			4'd0:    begin col = 2'd0; row = 2'd0; end
			4'd1:    begin col = 2'd1; row = 2'd0; end
			4'd2:    begin col = 2'd2; row = 2'd0; end
			4'd3:    begin col = 2'd0; row = 2'd1; end
			4'd4:    begin col = 2'd1; row = 2'd1; end
			4'd5:    begin col = 2'd2; row = 2'd1; end
			4'd6:    begin col = 2'd0; row = 2'd2; end
			4'd7:    begin col = 2'd1; row = 2'd2; end
			default: begin col = 2'd2; row = 2'd2; end
		endcase
	end

	// neighbor coordinates, out-of-grid neighbors read as alive
	assign nx = x_q + XW'(col) - XW'(1);
	assign ny = y_q + YW'(row) - YW'(1);
	assign outside = (col == 2'd0 && x_q == '0) || (col == 2'd2 && CW'(x_q) + CW'(1) == w)
		|| (row == 2'd0 && y_q == '0) || (row == 2'd2 && RW'(y_q) + RW'(1) == h);

	always_comb begin
		case (mode_q)
			MODE_MCOL: dst = {y_q, XW'(w - CW'(1) - CW'(x_q))};
			MODE_MROW: dst = {YW'(h - RW'(1) - RW'(y_q)), x_q};
			default:   dst = {y_q, x_q};
		endcase
	end

	assign term    = out_s1 ? 1'b1 : a_rdata;
	assign sum_fin = sum_q + 4'(term);
	always_comb begin
		new_cell = center_q;
		if (!center_q && sum_fin >= birth_limit) begin
			new_cell = 1'b1;
		end else if (center_q && sum_fin <= death_limit) begin
			new_cell = 1'b0;
		end
	end

	assign last_col  = CW'(x_q) + CW'(1) == xl_q;
	assign last_cell = last_col && (RW'(y_q) + RW'(1) == yl_q);

	assign a_raddr = (state_q == S_STEP_RD) ? {ny, nx} : {y_q, x_q};
	assign b_raddr = {y_q, x_q};
	assign a_we    = xf_vld_s1;
	assign a_waddr = waddr_s1;
	assign a_wdata = (mode_q == MODE_COPY) ? b_rdata : a_rdata;
	assign b_we    = (state_q == S_STEP_WR);
	assign b_waddr = {y_q, x_q};
	assign b_wdata = new_cell;

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_MAIN;
			steps_q   <= '0;
			mode_q    <= MODE_COPY;
			x_q       <= '0;
			y_q       <= '0;
			xl_q      <= '0;
			yl_q      <= '0;
			nb_q      <= '0;
			sum_q     <= '0;
			st_vld_s1 <= 1'b0;
			xf_vld_s1 <= 1'b0;
		end else begin
			st_vld_s1 <= (state_q == S_STEP_RD);
			xf_vld_s1 <= (state_q == S_XFER);
			if (st_vld_s1 && nb_s1 != NB_CENTER) begin
				sum_q <= sum_fin;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						phase_q <= PH_MAIN;
						steps_q <= main_steps;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					x_q  <= '0;
					y_q  <= '0;
					nb_q <= '0;
					sum_q <= '0;
					unique case (phase_q)
						PH_MAIN, PH_MS1, PH_MS2: begin
							if (steps_q != '0) begin
								steps_q <= steps_q - 8'd1;
								xl_q    <= w;
								yl_q    <= h;
								state_q <= S_STEP_RD;
							end else begin
								phase_q <= phase_q + 3'd1;
								steps_q <= mirror_steps;
							end
						end
						PH_MCOL: begin
							phase_q <= phase_q + 3'd1;
							steps_q <= mirror_steps;
							if ((w >> 1) != '0) begin
								mode_q  <= MODE_MCOL;
								xl_q    <= w >> 1;
								yl_q    <= h;
								state_q <= S_XFER;
							end
						end
						PH_MROW: begin
							phase_q <= phase_q + 3'd1;
							steps_q <= mirror_steps;
							if ((h >> 1) != '0) begin
								mode_q  <= MODE_MROW;
								xl_q    <= w;
								yl_q    <= h >> 1;
								state_q <= S_XFER;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_STEP_RD: begin
					nb_q <= nb_q + 4'd1;
					if (nb_q == NB_LAST) begin
						state_q <= S_STEP_WR;
					end
				end
				S_STEP_WR: begin
					nb_q  <= '0;
					sum_q <= '0;
					if (last_cell) begin
						x_q     <= '0;
						y_q     <= '0;
						mode_q  <= MODE_COPY;
						state_q <= S_XFER;
					end else begin
						if (last_col) begin
							x_q <= '0;
							y_q <= y_q + YW'(1);
						end else begin
							x_q <= x_q + XW'(1);
						end
						state_q <= S_STEP_RD;
					end
				end
				S_XFER: begin
					if (last_cell) begin
						state_q <= S_DRAIN;
					end else if (last_col) begin
						x_q <= '0;
						y_q <= y_q + YW'(1);
					end else begin
						x_q <= x_q + XW'(1);
					end
				end
				S_DRAIN: state_q <= S_NEXT;
				S_FIN:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// read side bookkeeping, payload only
	always_ff @(posedge clk) begin
		out_s1   <= outside;
		nb_s1    <= nb_q;
		waddr_s1 <= dst;
		if (st_vld_s1 && nb_s1 == NB_CENTER) begin
			center_q <= a_rdata;
		end
	end

endmodule
